// ===== rtl/pekc_pkg.sv =====
// Package for the percent-escape key codec: item and result types,
// character constants, status codes and hex helper functions.
// No dependencies; compiled first.
`default_nettype none

package pekc_pkg;

  // Character constants
  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] PrintLo   = 8'd33;
  localparam logic [7:0] PrintHi   = 8'd126;

  // Depth of the result buffer: one escaped byte gives three characters
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusBadHex = 2'd1,
    StatusEmpty  = 2'd2,
    StatusCutOff = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhaseHigh = 2'd1,
    PhaseLow  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    status_e    status;
  } result_t;

  // Result group handed from the translator to the output buffer
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               cnt;
  } xlate_t;

  // Lower-case hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

  // Value of a hex digit in either case; bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      v = {1'b0, d[3:0]};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pekc_if.sv =====
// Stream interfaces of the percent-escape key codec: input characters
// and result characters, each with valid/ready. Plain logic payloads.
`default_nettype none

interface pekc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface pekc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output out_char_valid,
                  output out_last, output status, input ready);
  modport sink   (input valid, input out_char, input out_char_valid,
                  input out_last, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/pekc_in_reg.sv =====
// Input holding register of the codec: one item, freed when the
// translator takes it. Depends on pekc_pkg.
`default_nettype none

module pekc_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire pekc_pkg::item_t in_item_i,
  output logic                in_ready_o,
  output logic                item_valid_o,
  output pekc_pkg::item_t     item_o,
  input  wire logic           item_take_i
);
  import pekc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Free when empty or being emptied this cycle
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_i |-> valid_q)
    else $error("item taken from empty input register");
  a_hold_until_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !item_take_i |=> valid_q && $stable(item_q))
    else $error("input item lost before it was taken");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("transfer not held in input register");
`endif

endmodule

`default_nettype wire

// ===== rtl/pekc_xlate.sv =====
// Translator of the codec: mode register, decode state and the
// single-pass logic that maps one item to up to three results.
// Depends on pekc_pkg.
`default_nettype none

module pekc_xlate (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire pekc_pkg::item_t item_i,
  input  wire logic            take_i,
  output pekc_pkg::xlate_t     xlate_o
);
  import pekc_pkg::*;

  logic       mode_q;
  phase_e     phase_q, phase_d;
  logic [3:0] high_q, high_d;
  logic       started_q, started_d;
  logic       err_q, err_d;

  logic [7:0] c;
  logic       last;
  logic [4:0] hv;
  logic       fail;
  status_e    fail_status;
  logic       fail_last;
  logic       clear;
  xlate_t     x;

  assign c    = item_i.in_char;
  assign last = item_i.in_last;
  assign hv   = hex_value(c);

  // Decode decisions: fail and clear are applied after the case
  always_comb begin
    x           = '0;
    phase_d     = phase_q;
    high_d      = high_q;
    started_d   = started_q;
    err_d       = err_q;
    fail        = 1'b0;
    fail_status = StatusOk;
    fail_last   = 1'b1;
    clear       = 1'b0;

    if (!mode_q) begin
      // Encode: escape '%' and anything outside the printable range
      if (c == PctChar || c < PrintLo || c > PrintHi) begin
        x.res[0] = '{data: PctChar, data_valid: 1'b1, last: 1'b0, status: StatusOk};
        x.res[1] = '{data: hex_digit(c[7:4]), data_valid: 1'b1, last: 1'b0,
                     status: StatusOk};
        x.res[2] = '{data: hex_digit(c[3:0]), data_valid: 1'b1, last: last,
                     status: StatusOk};
        x.cnt    = 2'd3;
      end else begin
        x.res[0] = '{data: c, data_valid: 1'b1, last: last, status: StatusOk};
        x.cnt    = 2'd1;
      end
    end else if (err_q) begin
      // Dropping to the end of the key
      clear = (c == SpaceChar) || last;
    end else if (c == SpaceChar) begin
      if (phase_q != PhaseIdle) begin
        fail        = 1'b1;
        fail_status = StatusCutOff;
      end else if (!started_q) begin
        fail        = 1'b1;
        fail_status = StatusEmpty;
      end else begin
        x.res[0] = '{data: 8'd0, data_valid: 1'b0, last: 1'b1, status: StatusOk};
        x.cnt    = 2'd1;
        clear    = 1'b1;
      end
    end else begin
      case (phase_q)
        PhaseIdle: begin
          started_d = 1'b1;
          if (c == PctChar) begin
            if (last) begin
              fail        = 1'b1;
              fail_status = StatusCutOff;
            end else begin
              phase_d = PhaseHigh;
            end
          end else begin
            x.res[0] = '{data: c, data_valid: 1'b1, last: last, status: StatusOk};
            x.cnt    = 2'd1;
            clear    = last;
          end
        end
        PhaseHigh: begin
          if (hv[4]) begin
            fail        = 1'b1;
            fail_status = StatusBadHex;
            fail_last   = last;
          end else if (last) begin
            fail        = 1'b1;
            fail_status = StatusCutOff;
          end else begin
            high_d  = hv[3:0];
            phase_d = PhaseLow;
          end
        end
        PhaseLow: begin
          if (hv[4]) begin
            fail        = 1'b1;
            fail_status = StatusBadHex;
            fail_last   = last;
          end else begin
            x.res[0] = '{data: {high_q, hv[3:0]}, data_valid: 1'b1, last: last,
                         status: StatusOk};
            x.cnt    = 2'd1;
            phase_d  = PhaseIdle;
            high_d   = 4'd0;
            clear    = last;
          end
        end
        default: begin
          phase_d = PhaseIdle;
        end
      endcase
    end

    // Error result; keep dropping unless the key ends here
    if (fail) begin
      x.res[0] = '{data: 8'd0, data_valid: 1'b0, last: 1'b1, status: fail_status};
      x.cnt    = 2'd1;
      clear    = 1'b1;
    end
    if (clear) begin
      phase_d   = PhaseIdle;
      high_d    = 4'd0;
      started_d = 1'b0;
      err_d     = fail && !fail_last;
    end
  end

  assign xlate_o = x;

  // Mode and decode state; a mode write starts a fresh key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      phase_q   <= PhaseIdle;
      high_q    <= 4'd0;
      started_q <= 1'b0;
      err_q     <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q    <= cfg_wdata_i;
      phase_q   <= PhaseIdle;
      high_q    <= 4'd0;
      started_q <= 1'b0;
      err_q     <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      high_q    <= high_d;
      started_q <= started_d;
      err_q     <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_drop_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == PhaseIdle && !started_q && high_q == 4'd0)
    else $error("dropping state with escape in progress");
  a_encode_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> x.cnt == 2'd1 || x.cnt == 2'd3)
    else $error("encode result count not one or three");
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> phase_q == PhaseIdle && !started_q && !err_q)
    else $error("mode write left decode state behind");
  a_decode_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q |-> x.cnt <= 2'd1)
    else $error("decode produced more than one result");
`endif

endmodule

`default_nettype wire

// ===== rtl/pekc_out_buf.sv =====
// Result buffer of the codec: holds up to three results of one item
// and shifts them out one per transfer. Depends on pekc_pkg.
`default_nettype none

module pekc_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pekc_pkg::xlate_t xlate_i,
  input  wire logic             load_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  output pekc_pkg::result_t     out_res_o,
  input  wire logic             out_ready_i
);
  import pekc_pkg::*;

  result_t [MaxResults-1:0] res_q;
  logic [1:0]               cnt_q, cnt_d;
  logic                     pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  // Refill once the last waiting result leaves
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = xlate_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload shift register, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= xlate_i.res;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_res_o = res_q[0];

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd3)
    else $error("result count out of range");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("results loaded over waiting results");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cnt_q) && $stable(res_q[0]))
    else $error("waiting result changed during stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/percent_escape_key_codec.sv =====
// Top level of the percent-escape key codec: input register, translator
// and result buffer. Depends on pekc_pkg, pekc_if and the pekc_* modules.
//
// Use: set decode_mode through cfg_we_i/cfg_wdata_i while idle (0 escapes
// raw key bytes, 1 unescapes encoded characters); a write starts a fresh
// key. Characters enter on in_i, one transfer per valid and ready edge;
// results leave on out_o with out_char, out_char_valid, out_last, status.
// A result passes the input register and then the result buffer before
// it is offered on out_o.
// Throughput: while the receiver is ready, an item that gives at most one
// result is taken every cycle; an escaped byte gives three results and
// holds the next item until the last of them leaves the one-character port.
// In decode mode, an accepted '%' or first hex digit, or a dropped character, gives no result.
// When the receiver stalls, the waiting result holds, the buffer stays
// full and in_i.ready drops once the input register is also occupied.
// Reset clears the mode to encode, empties both registers and clears the
// decode state; no results are offered until new input arrives.
`default_nettype none

module percent_escape_key_codec (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  pekc_in_if.sink    in_i,
  pekc_out_if.source out_o
);
  import pekc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    can_load;
  xlate_t  xlate;
  result_t head;
  logic    out_valid;

  assign in_item = '{in_char: in_i.in_char, in_last: in_i.in_last};

  pekc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (take)
  );

  // Item moves on when the buffer can take its results
  assign take = item_valid && can_load;

  pekc_xlate u_xlate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .take_i      (take),
    .xlate_o     (xlate)
  );

  pekc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .xlate_i     (xlate),
    .load_i      (take),
    .can_load_o  (can_load),
    .out_valid_o (out_valid),
    .out_res_o   (head),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid          = out_valid;
  assign out_o.out_char       = head.data;
  assign out_o.out_char_valid = head.data_valid;
  assign out_o.out_last       = head.last;
  assign out_o.status         = head.status;

`ifndef SYNTHESIS
  a_no_output_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result offered right after reset");
  a_error_ends_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && head.status != StatusOk |-> head.last && !head.data_valid)
    else $error("error result not a bare end of key");
  a_bare_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !head.data_valid |-> head.last)
    else $error("bare result without end of key");
`endif

endmodule

`default_nettype wire

// ===== sim/percent_escape_key_codec_tb.sv =====
`timescale 1ns / 100ps
// Testbench for percent_escape_key_codec: directed and random keys in both modes,
// checked against an in-bench predictor. Depends on pekc_pkg, pekc_if and the RTL.

module percent_escape_key_codec_tb;
  import pekc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 6;

  // Predicts codec results per accepted character and holds them until they arrive
  class key_codec_tracker;
    logic        decode_on;
    phase_e      phase;
    logic [3:0]  hi_nib;
    logic        key_open;
    logic        dropping;
    result_t     pending_results[$];
    int unsigned mismatches;

    function new();
      decode_on  = 1'b0;
      mismatches = 0;
      clear_key();
    endfunction

    function void clear_key();
      phase    = PhaseIdle;
      hi_nib   = 4'd0;
      key_open = 1'b0;
      dropping = 1'b0;
    endfunction

    function void set_mode(logic m);
      decode_on = m;
      clear_key();
    endfunction

    function void push_result(logic [7:0] d, logic dv, logic l, status_e st);
      result_t r;
      r.data       = d;
      r.data_valid = dv;
      r.last       = l;
      r.status     = st;
      pending_results.push_back(r);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      logic [7:0] ch;
      case (n)
        4'ha: ch = "a";
        4'hb: ch = "b";
        4'hc: ch = "c";
        4'hd: ch = "d";
        4'he: ch = "e";
        4'hf: ch = "f";
        default: ch = "0" + {4'd0, n};
      endcase
      return ch;
    endfunction

    // 0..15 for a digit of either case, 16 otherwise
    function logic [4:0] digit_of(logic [7:0] c);
      logic [7:0] off;
      off = 8'd16;
      if (c >= "0" && c <= "9") off = c - "0";
      else if (c >= "a" && c <= "f") off = c - "a" + 8'd10;
      else if (c >= "A" && c <= "F") off = c - "A" + 8'd10;
      return off[4:0];
    endfunction

    // error result; unless the key ends here, drop input until it does
    function void abort_key(status_e st, logic ends);
      push_result(8'd0, 1'b0, 1'b1, st);
      clear_key();
      if (!ends) dropping = 1'b1;
    endfunction

    function void note_char(logic [7:0] c, logic l);
      logic [4:0] v;
      // encode: escape '%' and anything outside the printable range
      if (!decode_on) begin
        if (c == PctChar || c < PrintLo || c > PrintHi) begin
          push_result(PctChar, 1'b1, 1'b0, StatusOk);
          push_result(hex_char(c[7:4]), 1'b1, 1'b0, StatusOk);
          push_result(hex_char(c[3:0]), 1'b1, l, StatusOk);
        end else begin
          push_result(c, 1'b1, l, StatusOk);
        end
        return;
      end
      if (dropping) begin
        if (c == SpaceChar || l) clear_key();
        return;
      end
      // space ends the key
      if (c == SpaceChar) begin
        if (phase != PhaseIdle) abort_key(StatusCutOff, 1'b1);
        else if (!key_open) abort_key(StatusEmpty, 1'b1);
        else begin
          push_result(8'd0, 1'b0, 1'b1, StatusOk);
          clear_key();
        end
        return;
      end
      if (phase == PhaseIdle) begin
        key_open = 1'b1;
        if (c == PctChar) begin
          if (l) abort_key(StatusCutOff, 1'b1);
          else phase = PhaseHigh;
        end else begin
          push_result(c, 1'b1, l, StatusOk);
          if (l) clear_key();
        end
        return;
      end
      // inside an escape
      v = digit_of(c);
      if (v[4]) begin
        abort_key(StatusBadHex, l);
        return;
      end
      if (phase == PhaseHigh) begin
        if (l) abort_key(StatusCutOff, 1'b1);
        else begin
          hi_nib = v[3:0];
          phase  = PhaseLow;
        end
        return;
      end
      push_result({hi_nib, v[3:0]}, 1'b1, l, StatusOk);
      phase  = PhaseIdle;
      hi_nib = 4'd0;
      if (l) clear_key();
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result char %h valid %b last %b status %0d", $time,
                 got.data, got.data_valid, got.last, got.status);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.data !== want.data || got.data_valid !== want.data_valid ||
          got.last !== want.last || got.status !== want.status) begin
        $display("%0t: mismatch: expected char %h valid %b last %b status %0d", $time,
                 want.data, want.data_valid, want.last, want.status);
        $display("%0t:           actual   char %h valid %b last %b status %0d", $time,
                 got.data, got.data_valid, got.last, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   quiet_tail;
  int unsigned cycle_count;
  int unsigned stall_left;
  result_t seen;
  key_codec_tracker tracker;

  pekc_in_if  in_if ();
  pekc_out_if out_if ();

  percent_escape_key_codec i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("percent_escape_key_codec verification failed");
      $finish;
    end
  end

  // receiver: ready with random stall bursts, none in the tail
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.data       = out_if.out_char;
      seen.data_valid = out_if.out_char_valid;
      seen.last       = out_if.out_last;
      seen.status     = status_e'(out_if.status);
      tracker.check_result(seen);
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic drive_char(input logic [7:0] c, input logic l);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.in_char <= c;
    in_if.in_last <= l;
    do begin
      @(posedge clk);
    end while (in_if.ready !== 1'b1);
    tracker.note_char(c, l);
  endtask

  // mode write once the codec has drained
  task automatic load_mode(input logic m);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_mode(m);
  endtask

  function automatic logic [7:0] hex_text(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) ch = 8'h30 + {4'd0, n};
    else if ($urandom_range(0, 1) == 1) ch = 8'h37 + {4'd0, n};
    else ch = 8'h57 + {4'd0, n};
    return ch;
  endfunction

  task automatic run_encode_phase(input int unsigned count);
    logic [7:0] c;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: c = PctChar;
        1: c = ($urandom_range(0, 1) == 1) ? PrintLo - 8'd1 : PrintHi + 8'd1;
        2: c = ($urandom_range(0, 1) == 1) ? PrintLo : PrintHi;
        default: c = 8'($urandom_range(0, 255));
      endcase
      drive_char(c, $urandom_range(0, 3) == 0);
    end
  endtask

  // mostly well-formed keys, some noise and broken escapes
  task automatic run_decode_phase(input int unsigned count);
    logic [7:0]  key_q[$];
    logic [7:0]  c;
    logic        space_end;
    int unsigned sent;
    int          k;
    sent = 0;
    while (sent < count) begin
      key_q.delete();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: c = PctChar;
            1: c = SpaceChar;
            2: c = hex_text(4'($urandom_range(0, 15)));
            default: c = 8'($urandom_range(0, 255));
          endcase
          drive_char(c, $urandom_range(0, 5) == 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 9) < 7) begin
            do begin
              c = 8'($urandom_range(0, 255));
            end while (c == SpaceChar || c == PctChar);
            key_q.push_back(c);
          end else begin
            key_q.push_back(PctChar);
            key_q.push_back(hex_text(4'($urandom_range(0, 15))));
            key_q.push_back(hex_text(4'($urandom_range(0, 15))));
          end
        end
        space_end = 1'($urandom_range(0, 1));
        if (space_end) key_q.push_back(SpaceChar);
        for (k = 0; k < key_q.size(); k++) begin
          drive_char(key_q[k], (k == key_q.size() - 1) &&
                               (!space_end || $urandom_range(0, 3) == 0));
          sent++;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    quiet_tail    = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_char = 8'd0;
    in_if.in_last = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // encode extremes, reset mode
    drive_char(8'h00, 1'b0);
    drive_char(8'hFF, 1'b1);
    drive_char(PctChar, 1'b0);
    drive_char(PrintLo, 1'b0);
    drive_char(PrintHi, 1'b0);
    drive_char(SpaceChar, 1'b1);

    load_mode(1'b1);
    // plain char, escapes in both cases, last on the low digit
    drive_char("k", 1'b0);
    drive_char(PctChar, 1'b0);
    drive_char("4", 1'b0);
    drive_char("a", 1'b0);
    drive_char(PctChar, 1'b0);
    drive_char("F", 1'b0);
    drive_char("f", 1'b1);
    // empty key
    drive_char(SpaceChar, 1'b0);
    // bad digit, then dropped up to the space
    drive_char(PctChar, 1'b0);
    drive_char("g", 1'b0);
    drive_char("x", 1'b0);
    drive_char(SpaceChar, 1'b0);
    // cut-off escapes: last on '%', last on first digit, space inside
    drive_char(PctChar, 1'b1);
    drive_char(PctChar, 1'b0);
    drive_char("3", 1'b1);
    drive_char("a", 1'b0);
    drive_char(PctChar, 1'b0);
    drive_char(SpaceChar, 1'b0);
    // zero byte as a plain char, space carrying last
    drive_char(8'h00, 1'b1);
    drive_char("z", 1'b0);
    drive_char(SpaceChar, 1'b1);

    load_mode(1'b0);
    run_encode_phase(120);
    load_mode(1'b1);
    run_decode_phase(150);
    load_mode(1'b0);
    run_encode_phase(60);
    load_mode(1'b1);
    run_decode_phase(90);
    quiet_tail = 1'b1;
    run_decode_phase(60);

    // drain
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("percent_escape_key_codec verification clean");
    end else begin
      $display("percent_escape_key_codec verification failed");
    end
    $finish;
  end

endmodule
